// ----- src/bcdc_pkg.sv -----
package bcdc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_STATUS  = 4'd1;
  localparam logic [3:0] REG_INITVAL = 4'd2;
  localparam logic [3:0] REG_DATA    = 4'd3;

  localparam int CTRL_EN   = 0;
  localparam int CTRL_IEN  = 1;
  localparam int CTRL_FREQ = 2;
  localparam int ST_INITW  = 0;
  localparam int ST_IFG    = 1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  word_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } rsp_t;

  // Increment of a four-digit BCD value; 9999 wraps to 0000.
  function automatic logic [15:0] bcd_next(input logic [15:0] v);
    logic [15:0] n;
    n = v + 16'd1;
    if (n[3:0] > 4'h9) begin
      n = n + 16'h0006;
      if (n[7:4] > 4'h9) begin
        n = n + 16'h0060;
        if (n[11:8] > 4'h9) begin
          n = n + 16'h0600;
          if (n[15:12] > 4'h9) begin
            n = n + 16'h6000;
          end
        end
      end
    end
    return n;
  endfunction

  function automatic logic not_bcd(input logic [31:0] v);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (v[4*i +: 4] > 4'h9) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

// ----- src/bcdc_in_reg.sv -----
module bcdc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bcdc_pkg::req_t req,
  input  logic          advance,
  output logic          hold_valid,
  output bcdc_pkg::req_t hold
);

  assign req_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

endmodule

// ----- src/bcdc_core.sv -----
module bcdc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  bcdc_pkg::req_t item,
  output bcdc_pkg::rsp_t result
);

  logic [2:0]  ctrl_bits;
  logic [1:0]  status_bits;
  logic [15:0] init_value;
  logic [15:0] count_value;
  logic        half_tick;

  logic [2:0]  ctrl_bits_next;
  logic [1:0]  status_bits_next;
  logic [15:0] init_value_next;
  logic [15:0] count_value_next;
  logic        half_tick_next;
  logic [31:0] read_data;
  logic        count;

  always_comb begin
    ctrl_bits_next   = ctrl_bits;
    status_bits_next = status_bits;
    init_value_next  = init_value;
    count_value_next = count_value;
    half_tick_next   = half_tick;
    read_data        = 32'd0;
    count            = 1'b0;
    case (bcdc_pkg::action_t'(item.action))
      bcdc_pkg::ACT_TICK: begin
        if (ctrl_bits[bcdc_pkg::CTRL_EN]) begin
          if (ctrl_bits[bcdc_pkg::CTRL_FREQ] || half_tick) begin
            half_tick_next = 1'b0;
            count          = 1'b1;
          end else begin
            half_tick_next = 1'b1;
          end
        end
        if (count) begin
          count_value_next                  = bcdc_pkg::bcd_next(count_value);
          status_bits_next[bcdc_pkg::ST_IFG] = 1'b1;
        end
      end
      bcdc_pkg::ACT_READ: begin
        case (item.word_index)
          bcdc_pkg::REG_CTRL:    read_data = {29'd0, ctrl_bits};
          bcdc_pkg::REG_STATUS:  read_data = {30'd0, status_bits};
          bcdc_pkg::REG_INITVAL: read_data = {16'd0, init_value};
          bcdc_pkg::REG_DATA:    read_data = {16'd0, count_value};
          default:               read_data = 32'd0;
        endcase
      end
      bcdc_pkg::ACT_WRITE: begin
        case (item.word_index)
          bcdc_pkg::REG_CTRL: begin
            ctrl_bits_next = item.write_data[2:0];
            if (item.write_data[bcdc_pkg::CTRL_FREQ] != ctrl_bits[bcdc_pkg::CTRL_FREQ]) begin
              half_tick_next = 1'b0;
            end
            if (item.write_data[bcdc_pkg::CTRL_EN] && !ctrl_bits[bcdc_pkg::CTRL_EN]) begin
              count_value_next = status_bits[bcdc_pkg::ST_INITW] ? 16'd0 : init_value;
              half_tick_next   = 1'b0;
            end
          end
          bcdc_pkg::REG_STATUS: begin
            status_bits_next[bcdc_pkg::ST_IFG] = item.write_data[bcdc_pkg::ST_IFG];
          end
          bcdc_pkg::REG_INITVAL: begin
            init_value_next                      = item.write_data[15:0];
            status_bits_next[bcdc_pkg::ST_INITW] = bcdc_pkg::not_bcd(item.write_data);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign result.read_data = read_data;
  assign result.irq       = ctrl_bits_next[bcdc_pkg::CTRL_IEN] &&
                            status_bits_next[bcdc_pkg::ST_IFG];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_bits   <= 3'd0;
      status_bits <= 2'd0;
      init_value  <= 16'd0;
      count_value <= 16'd0;
      half_tick   <= 1'b0;
    end else if (step) begin
      ctrl_bits   <= ctrl_bits_next;
      status_bits <= status_bits_next;
      init_value  <= init_value_next;
      count_value <= count_value_next;
      half_tick   <= half_tick_next;
    end
  end

endmodule

// ----- src/bcdc_out_reg.sv -----
module bcdc_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bcdc_pkg::rsp_t result,
  output logic           free,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bcdc_pkg::rsp_t rsp
);

  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= load;
    end
    if (load && free) begin
      rsp <= result;
    end
  end

endmodule

// ----- src/bcd_sample_counter_device.sv -----
// Path: an accepted request item is held in the input register, then moves into
// the response register. Throughput: one item per cycle while rsp_ready allows;
// the register state is updated as the item moves between the two registers.
// Reset: synchronous, active high; clears the device registers and the
// pipeline valid flags.
module bcd_sample_counter_device (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bcdc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bcdc_pkg::rsp_t rsp
);

  logic           hold_valid;
  bcdc_pkg::req_t hold;
  logic           free;
  logic           advance;
  bcdc_pkg::rsp_t result;

  assign advance = hold_valid && free;

  bcdc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold       (hold)
  );

  bcdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold),
    .result (result)
  );

  bcdc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.read_data[31:16] == 16'd0)
    else $error("response read data has upper bits set");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled while response register empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

// ----- bench/bcd_sample_counter_device_test.sv -----
`timescale 1ns / 1ps

module bcd_sample_counter_device_test;

  localparam int RANDOM_ITEMS = 1400;
  localparam int LOG_LIMIT = 50;

  typedef struct {
    bcdc_pkg::req_t access;
    bit             fixed;
    bcdc_pkg::rsp_t fixed_rsp;
  } access_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bcdc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bcdc_pkg::rsp_t rsp;

  bit             req_fixed = 1'b0;
  bcdc_pkg::rsp_t req_fixed_rsp = '0;

  logic [2:0]  dev_ctrl = '0;
  logic [1:0]  dev_status = '0;
  logic [15:0] dev_init = '0;
  logic [15:0] dev_count = '0;
  logic        dev_half = 1'b0;

  bcdc_pkg::rsp_t awaited_rsp[$];
  access_row_t    dir_rows[$];

  int error_count = 0;
  int items_sent = 0;
  int rsp_checked = 0;
  int counts_seen = 0;
  int wraps_seen = 0;
  int holds_done = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  bcd_sample_counter_device uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Advances the device state by one access and returns its response.
  function automatic bcdc_pkg::rsp_t predict_access(input bcdc_pkg::req_t r);
    bcdc_pkg::rsp_t o;
    logic [2:0]     nc;
    logic           carry;
    logic           bad;
    int             d;
    o = '0;
    case (r.action)
      bcdc_pkg::ACT_TICK: begin
        if (dev_ctrl[bcdc_pkg::CTRL_EN]) begin
          if (dev_ctrl[bcdc_pkg::CTRL_FREQ] || dev_half) begin
            dev_half = 1'b0;
            carry = 1'b1;
            for (d = 0; d < 4; d++) begin
              if (carry) begin
                if (dev_count[4*d +: 4] >= 4'd9) begin
                  dev_count[4*d +: 4] = 4'd0;
                end else begin
                  dev_count[4*d +: 4] = dev_count[4*d +: 4] + 4'd1;
                  carry = 1'b0;
                end
              end
            end
            if (carry) wraps_seen++;
            counts_seen++;
            dev_status[bcdc_pkg::ST_IFG] = 1'b1;
          end else begin
            dev_half = 1'b1;
          end
        end
      end
      bcdc_pkg::ACT_READ: begin
        case (r.word_index)
          bcdc_pkg::REG_CTRL:    o.read_data = {29'd0, dev_ctrl};
          bcdc_pkg::REG_STATUS:  o.read_data = {30'd0, dev_status};
          bcdc_pkg::REG_INITVAL: o.read_data = {16'd0, dev_init};
          bcdc_pkg::REG_DATA:    o.read_data = {16'd0, dev_count};
          default:               o.read_data = '0;
        endcase
      end
      bcdc_pkg::ACT_WRITE: begin
        case (r.word_index)
          bcdc_pkg::REG_CTRL: begin
            nc = r.write_data[2:0];
            if (nc[bcdc_pkg::CTRL_FREQ] != dev_ctrl[bcdc_pkg::CTRL_FREQ]) dev_half = 1'b0;
            if (nc[bcdc_pkg::CTRL_EN] && !dev_ctrl[bcdc_pkg::CTRL_EN]) begin
              dev_count = dev_status[bcdc_pkg::ST_INITW] ? 16'd0 : dev_init;
              dev_half = 1'b0;
            end
            dev_ctrl = nc;
          end
          bcdc_pkg::REG_STATUS:
            dev_status[bcdc_pkg::ST_IFG] = r.write_data[bcdc_pkg::ST_IFG];
          bcdc_pkg::REG_INITVAL: begin
            bad = 1'b0;
            for (d = 0; d < 8; d++) begin
              if (r.write_data[4*d +: 4] > 4'd9) bad = 1'b1;
            end
            dev_init = r.write_data[15:0];
            dev_status[bcdc_pkg::ST_INITW] = bad;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.irq = dev_ctrl[bcdc_pkg::CTRL_IEN] & dev_status[bcdc_pkg::ST_IFG];
    return o;
  endfunction

  function automatic void add_row(input bcdc_pkg::action_t act, input logic [3:0] idx,
                                  input logic [31:0] data, input bit fixed,
                                  input logic [31:0] rd, input logic irq);
    access_row_t row;
    row.access.action = act;
    row.access.word_index = idx;
    row.access.write_data = data;
    row.fixed = fixed;
    row.fixed_rsp.read_data = rd;
    row.fixed_rsp.irq = irq;
    dir_rows.push_back(row);
  endfunction

  function automatic bcdc_pkg::req_t random_access();
    bcdc_pkg::req_t r;
    int             pick;
    int             d;
    r.action = bcdc_pkg::ACT_READ;
    r.word_index = bcdc_pkg::REG_CTRL;
    r.write_data = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      r.action = bcdc_pkg::ACT_TICK;
      r.word_index = 4'($urandom);
    end else if (pick < 63) begin
      r.word_index = ($urandom_range(4, 0) == 0) ? 4'($urandom) : 4'($urandom_range(3, 0));
    end else if (pick < 74) begin
      r.action = bcdc_pkg::ACT_WRITE;
      r.word_index = bcdc_pkg::REG_CTRL;
      if ($urandom_range(1, 0) != 0) r.write_data[31:3] = '0;
      r.write_data[bcdc_pkg::CTRL_EN] = ($urandom_range(4, 0) != 0);
    end else if (pick < 81) begin
      r.action = bcdc_pkg::ACT_WRITE;
      r.word_index = bcdc_pkg::REG_STATUS;
    end else if (pick < 90) begin
      r.action = bcdc_pkg::ACT_WRITE;
      r.word_index = bcdc_pkg::REG_INITVAL;
      if ($urandom_range(3, 0) != 0) begin
        r.write_data = '0;
        for (d = 0; d < 4; d++) r.write_data[4*d +: 4] = 4'($urandom_range(9, 0));
        if ($urandom_range(2, 0) == 0) r.write_data[15:8] = 8'h99;
      end
    end else if (pick < 94) begin
      r.action = bcdc_pkg::ACT_WRITE;
      r.word_index = bcdc_pkg::REG_DATA;
    end else if (pick < 97) begin
      r.action = bcdc_pkg::ACT_WRITE;
      r.word_index = 4'($urandom_range(15, 4));
    end else begin
      r.action = bcdc_pkg::ACT_NONE;
      r.word_index = 4'($urandom);
    end
    return r;
  endfunction

  task automatic offer_access(input bcdc_pkg::req_t r, input bit fixed,
                              input bcdc_pkg::rsp_t fixed_rsp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if ($urandom_range(3, 0) != 0) begin
        gap = $urandom_range(5, 1);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= r;
    req_fixed <= fixed;
    req_fixed_rsp <= fixed_rsp;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  always @(posedge clk) begin
    bcdc_pkg::rsp_t want;
    bcdc_pkg::rsp_t pred;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          error_count++;
          if (error_count <= LOG_LIMIT)
            $display("%0t: unexpected response item read_data=%h irq=%b",
                     $time, rsp.read_data, rsp.irq);
        end else begin
          want = awaited_rsp.pop_front();
          rsp_checked++;
          if (rsp.read_data !== want.read_data) begin
            error_count++;
            if (error_count <= LOG_LIMIT)
              $display("%0t: read_data expected %h actual %h",
                       $time, want.read_data, rsp.read_data);
          end
          if (rsp.irq !== want.irq) begin
            error_count++;
            if (error_count <= LOG_LIMIT)
              $display("%0t: irq expected %b actual %b", $time, want.irq, rsp.irq);
          end
        end
      end
      if (req_valid && req_ready) begin
        pred = predict_access(req);
        awaited_rsp.push_back(req_fixed ? req_fixed_rsp : pred);
      end
    end
  end

  initial begin
    int hold_left;
    int mode;
    int mode_left;
    int rx_cycle;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_off_req && hold_left == 0) begin
        hold_off_req = 1'b0;
        hold_left = 64;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3, 0);
        mode_left = $urandom_range(150, 20);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(3, 0) != 0);
          2: rsp_ready <= ($urandom_range(9, 0) < 3);
          default: rsp_ready <= rx_cycle[1] ^ rx_cycle[3];
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("bcd_sample_counter_device regression: fail");
    $finish;
  end

  initial begin
    int             i;
    int             drain;
    bcdc_pkg::rsp_t none;
    none = '0;

    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_CTRL, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_STATUS, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_TICK, bcdc_pkg::REG_CTRL, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_INITVAL, 32'h0000_9998, 1, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_INITVAL, 32'h0000_0000, 1, 32'h0000_9998, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_CTRL, 32'h0000_0007, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_TICK, bcdc_pkg::REG_CTRL, 32'h0000_0000, 1, 32'h0000_0000, 1'b1);
    add_row(bcdc_pkg::ACT_TICK, bcdc_pkg::REG_CTRL, 32'h0000_0000, 1, 32'h0000_0000, 1'b1);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_DATA, 32'h0000_0000, 1, 32'h0000_0000, 1'b1);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_STATUS, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_CTRL, 32'hFFFF_FFFB, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_CTRL, 32'h0000_0000, 1, 32'h0000_0003, 1'b0);
    add_row(bcdc_pkg::ACT_TICK, 4'hF, 32'hFFFF_FFFF, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_TICK, bcdc_pkg::REG_CTRL, 32'h0000_0000, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_INITVAL, 32'hA000_0000, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_STATUS, 32'h0000_0000, 1, 32'h0000_0003, 1'b1);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_STATUS, 32'hFFFF_FFFD, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_DATA, 32'h0000_1234, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_READ, bcdc_pkg::REG_DATA, 32'h0000_0000, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_CTRL, 32'h0000_0000, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_CTRL, 32'h0000_0005, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, bcdc_pkg::REG_INITVAL, 32'h9999_9999, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_WRITE, 4'hF, 32'hFFFF_FFFF, 0, 32'h0, 1'b0);
    add_row(bcdc_pkg::ACT_READ, 4'hF, 32'h0000_0000, 1, 32'h0000_0000, 1'b0);
    add_row(bcdc_pkg::ACT_NONE, bcdc_pkg::REG_CTRL, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) offer_access(dir_rows[k].access, dir_rows[k].fixed,
                                       dir_rows[k].fixed_rsp);

    hold_off_req = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_off_req = 1'b1;
      offer_access(random_access(), 1'b0, none);
    end
    req_valid <= 1'b0;

    drain = 0;
    while (awaited_rsp.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (awaited_rsp.size() != 0) begin
      error_count++;
      $display("%0t: %0d response items never arrived", $time, awaited_rsp.size());
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d accesses (%0d directed), checked %0d responses, %0d errors.",
             items_sent, dir_rows.size(), rsp_checked, error_count);
    $display("Counter advanced %0d times with %0d wraps; %0d long response stalls.",
             counts_seen, wraps_seen, holds_done);
    if (error_count == 0) begin
      $display("bcd_sample_counter_device regression: pass");
    end else begin
      $display("bcd_sample_counter_device regression: fail");
    end
    $finish;
  end

endmodule
